@@ hw/rtl/ebfd_pkg.sv @@
// Shared types and codes for the encrypted body frame deframer.
// No dependencies.

package ebfd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  region;
        logic [1:0]  frame_kind;
        logic [31:0] frame_seq;
        logic [35:0] body_length;
        logic [35:0] frame_length;
        logic        frame_done;
        logic [1:0]  error_code;
    } out_word_t;

    typedef struct packed {
        logic [31:0] max_frame_bytes;
        logic [7:0]  iv_bytes;
        logic [7:0]  tag_bytes;
    } cfg_t;

    localparam logic [1:0] CFG_MAX_FRAME = 2'd0;
    localparam logic [1:0] CFG_IV        = 2'd1;
    localparam logic [1:0] CFG_TAG       = 2'd2;

    localparam logic [31:0] MAX_FRAME_RESET = 32'd4096;
    localparam logic [7:0]  IV_RESET        = 8'd12;
    localparam logic [7:0]  TAG_RESET       = 8'd16;

    localparam logic [2:0] REGION_SEQ  = 3'd0;
    localparam logic [2:0] REGION_FSEQ = 3'd1;
    localparam logic [2:0] REGION_IV   = 3'd2;
    localparam logic [2:0] REGION_LEN  = 3'd3;
    localparam logic [2:0] REGION_BODY = 3'd4;
    localparam logic [2:0] REGION_TAG  = 3'd5;

    localparam logic [1:0] KIND_REG    = 2'd0;
    localparam logic [1:0] KIND_FINAL  = 2'd1;
    localparam logic [1:0] KIND_SINGLE = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_FINAL_LEN = 2'd1;
    localparam logic [1:0] ERR_LIMIT     = 2'd2;

    localparam logic [31:0] FINAL_MARK = 32'hFFFF_FFFF;

endpackage

@@ hw/rtl/encrypted_body_frame_deframer.sv @@
// Encrypted body frame deframer top level: input register, frame parser, result register.
// Depends on ebfd_pkg and ebfd_cfg.

// Labels each byte of an encrypted body stream with its frame region (sequence word,
// final sequence number, IV, length field, body, tag) and reports the frame's kind,
// sequence number, body and total lengths, the last byte of each frame and sticky
// length errors. One word in, one word out, one word per cycle sustained while the
// receiver is ready: each byte passes an input register, combinational parsing logic
// against the frame state, and a result register. While a result waits, one more word
// is taken into the input register. Lengths are limited to LENGTH_BITS bits; the user
// must write configuration only while the block is empty (the block does not enforce
// this), and it takes effect at the next parsed byte.

module encrypted_body_frame_deframer #(
    parameter int LENGTH_BITS = 36
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ebfd_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output ebfd_pkg::out_word_t out_word,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import ebfd_pkg::*;

    localparam int LW = (LENGTH_BITS > 36) ? LENGTH_BITS : 36;

    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_SEQ   = 4'd1;
    localparam logic [3:0] PH_FSEQ  = 4'd2;
    localparam logic [3:0] PH_IV    = 4'd3;
    localparam logic [3:0] PH_LEN   = 4'd4;
    localparam logic [3:0] PH_BODY  = 4'd5;
    localparam logic [3:0] PH_TAG   = 4'd6;
    localparam logic [3:0] PH_DONE  = 4'd7;
    localparam logic [3:0] PH_ERR   = 4'd8;

    cfg_t cfg;

    ebfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic      s1_valid_reg, s1_valid_next;
    in_word_t  s1_word_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;
    logic      fire;

    logic [3:0]    phase_reg, phase_next;
    logic [LW-1:0] count_reg, count_next;
    logic [63:0]   shift_reg, shift_next;
    logic [31:0]   seq_reg, seq_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] total_reg, total_next;
    logic [1:0]    kind_reg, kind_next;
    logic [1:0]    error_reg, error_next;

    function automatic logic [3:0] next_phase(input logic [3:0] p, input logic [1:0] kind);
        logic [3:0] r;
        case (p)
            PH_SEQ:  r = (kind == KIND_FINAL) ? PH_FSEQ : PH_IV;
            PH_FSEQ: r = PH_IV;
            PH_IV:   r = (kind == KIND_REG) ? PH_BODY : PH_LEN;
            PH_LEN:  r = PH_BODY;
            PH_BODY: r = PH_TAG;
            default: r = PH_DONE;
        endcase
        return r;
    endfunction

    // skip empty IV, body and tag regions
    function automatic logic [3:0] skip_empty(input logic [3:0] p, input logic [1:0] kind,
                                              input logic [LW-1:0] len, input cfg_t c);
        logic [3:0] r;
        r = p;
        if (r == PH_IV && c.iv_bytes == 8'd0)
            r = (kind == KIND_REG) ? PH_BODY : PH_LEN;
        if (r == PH_BODY && len == '0)
            r = PH_TAG;
        if (r == PH_TAG && c.tag_bytes == 8'd0)
            r = PH_DONE;
        return r;
    endfunction

    function automatic logic [2:0] region_of(input logic [3:0] p);
        logic [2:0] r;
        case (p)
            PH_SEQ:  r = REGION_SEQ;
            PH_FSEQ: r = REGION_FSEQ;
            PH_IV:   r = REGION_IV;
            PH_LEN:  r = REGION_LEN;
            PH_BODY: r = REGION_BODY;
            default: r = REGION_TAG;
        endcase
        return r;
    endfunction

    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        logic [3:0]    cur_ph;
        logic [LW-1:0] rlen;
        logic [63:0]   len_arg;
        logic [9:0]    ovh;
        logic [64:0]   sum;
        logic          chk;
        logic [1:0]    err;
        logic [2:0]    region;
        logic          done;

        phase_next = phase_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        total_next = total_reg;
        kind_next  = kind_reg;
        error_next = error_reg;
        cur_ph     = PH_START;
        rlen       = '0;
        len_arg    = '0;
        ovh        = '0;
        sum        = '0;
        chk        = 1'b0;
        err        = ERR_NONE;
        region     = REGION_TAG;
        done       = 1'b0;

        if (s1_word_reg.restart)
        begin
            phase_next = PH_START;
            error_next = ERR_NONE;
        end

        if (phase_next == PH_START)
        begin
            seq_next   = '0;
            len_next   = '0;
            total_next = '0;
            count_next = '0;
            shift_next = '0;
            if (cfg.max_frame_bytes == 32'd0)
            begin
                kind_next  = KIND_SINGLE;
                seq_next   = 32'd1;
                phase_next = skip_empty(PH_IV, KIND_SINGLE, '0, cfg);
            end
            else
            begin
                kind_next  = KIND_REG;
                phase_next = PH_SEQ;
            end
        end

        if (phase_next != PH_ERR)
        begin
            cur_ph     = phase_next;
            region     = region_of(cur_ph);
            shift_next = {shift_next[55:0], s1_word_reg.data_byte};
            count_next = count_next + LW'(1);
            case (cur_ph)
                PH_SEQ, PH_FSEQ: rlen = LW'(4);
                PH_IV:           rlen = LW'(cfg.iv_bytes);
                PH_LEN:          rlen = (kind_next == KIND_SINGLE) ? LW'(8) : LW'(4);
                PH_BODY:         rlen = len_next;
                PH_TAG:          rlen = LW'(cfg.tag_bytes);
                default:         rlen = LW'(1);
            endcase

            if (count_next >= rlen)
            begin
                case (cur_ph)
                    PH_SEQ:
                    begin
                        if (shift_next[31:0] == FINAL_MARK)
                        begin
                            kind_next = KIND_FINAL;
                        end
                        else
                        begin
                            seq_next = shift_next[31:0];
                            len_arg  = {32'd0, cfg.max_frame_bytes};
                            ovh      = 10'd4 + 10'(cfg.iv_bytes) + 10'(cfg.tag_bytes);
                            chk      = 1'b1;
                        end
                    end
                    PH_FSEQ:
                    begin
                        seq_next = shift_next[31:0];
                    end
                    PH_LEN:
                    begin
                        if (kind_next == KIND_FINAL)
                        begin
                            if (shift_next[31:0] > cfg.max_frame_bytes)
                            begin
                                len_next = LW'(shift_next[31:0]);
                                err      = ERR_FINAL_LEN;
                            end
                            else
                            begin
                                len_arg = {32'd0, shift_next[31:0]};
                                ovh     = 10'd12 + 10'(cfg.iv_bytes) + 10'(cfg.tag_bytes);
                                chk     = 1'b1;
                            end
                        end
                        else
                        begin
                            len_arg = shift_next;
                            ovh     = 10'd8 + 10'(cfg.iv_bytes) + 10'(cfg.tag_bytes);
                            chk     = 1'b1;
                        end
                    end
                    default:
                    begin
                        chk = 1'b0;
                    end
                endcase

                if (chk)
                begin
                    len_next = len_arg[LW-1:0];
                    sum      = {1'b0, len_arg} + 65'(ovh);
                    if (|sum[64:LENGTH_BITS])
                        err = ERR_LIMIT;
                    else
                        total_next = sum[LW-1:0];
                end

                if (err != ERR_NONE)
                begin
                    error_next = err;
                    phase_next = PH_ERR;
                end
                else
                begin
                    phase_next = skip_empty(next_phase(cur_ph, kind_next), kind_next,
                                            len_next, cfg);
                    count_next = '0;
                    shift_next = '0;
                    if (phase_next == PH_DONE)
                    begin
                        done       = 1'b1;
                        phase_next = PH_START;
                    end
                end
            end
        end

        out_word_next.byte_out     = s1_word_reg.data_byte;
        out_word_next.region       = region;
        out_word_next.frame_kind   = kind_next;
        out_word_next.frame_seq    = seq_next;
        out_word_next.body_length  = len_next[35:0];
        out_word_next.frame_length = total_next[35:0];
        out_word_next.frame_done   = done;
        out_word_next.error_code   = error_next;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
            s1_valid_next = in_valid;
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            count_reg     <= '0;
            shift_reg     <= '0;
            seq_reg       <= '0;
            len_reg       <= '0;
            total_reg     <= '0;
            kind_reg      <= KIND_REG;
            error_reg     <= ERR_NONE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                shift_reg <= shift_next;
                seq_reg   <= seq_next;
                len_reg   <= len_next;
                total_reg <= total_next;
                kind_reg  <= kind_next;
                error_reg <= error_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_word_reg <= in_word;
        if (fire)
            out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

@@ hw/rtl/ebfd_cfg.sv @@
// Configuration register file: frame size, IV length and tag length.
// Depends on ebfd_pkg.

module ebfd_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output ebfd_pkg::cfg_t     cfg
);
    import ebfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_FRAME: cfg_next.max_frame_bytes = cfg_data;
                CFG_IV:        cfg_next.iv_bytes = cfg_data[7:0];
                CFG_TAG:       cfg_next.tag_bytes = cfg_data[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_bytes <= MAX_FRAME_RESET;
            cfg_reg.iv_bytes        <= IV_RESET;
            cfg_reg.tag_bytes       <= TAG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ bench/ebfd_frame_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the encrypted body frame deframer. It follows the config port,
// predicts the labeled word for each accepted byte and checks every output word.
// Depends on ebfd_pkg.

module ebfd_frame_checker #(
    parameter int LENGTH_BITS = 36
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  ebfd_pkg::in_word_t  in_word,
    input  logic                out_valid,
    input  logic                out_ready,
    input  ebfd_pkg::out_word_t out_word,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  fail_count,
    output int                  pending
);
    import ebfd_pkg::*;

    typedef enum logic [3:0] {
        ST_START, ST_SEQ, ST_FSEQ, ST_IV, ST_LEN, ST_BODY, ST_TAG, ST_DONE, ST_ERR
    } parse_st_t;

    localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

    logic [31:0] max_frame;
    logic [7:0]  iv_len;
    logic [7:0]  tag_len;
    parse_st_t   st;
    logic [63:0] region_cnt;
    logic [63:0] shift_acc;
    logic [31:0] seq_no;
    logic [63:0] body_len;
    logic [63:0] total_len;
    logic [1:0]  kind;
    logic [1:0]  held_err;
    out_word_t   awaited_labels [$];
    int          word_no = 0;
    int          errs = 0;
    int          queued = 0;

    assign fail_count = errs;
    assign pending    = queued;

    function automatic logic [63:0] region_span(input parse_st_t s);
        case (s)
            ST_SEQ, ST_FSEQ: return 64'd4;
            ST_IV:           return {56'd0, iv_len};
            ST_LEN:          return (kind == KIND_SINGLE) ? 64'd8 : 64'd4;
            ST_BODY:         return body_len;
            ST_TAG:          return {56'd0, tag_len};
            default:         return 64'd1;
        endcase
    endfunction

    function automatic parse_st_t next_region(input parse_st_t s);
        case (s)
            ST_SEQ:  return (kind == KIND_FINAL) ? ST_FSEQ : ST_IV;
            ST_FSEQ: return ST_IV;
            ST_IV:   return (kind == KIND_REG) ? ST_BODY : ST_LEN;
            ST_LEN:  return ST_BODY;
            ST_BODY: return ST_TAG;
            default: return ST_DONE;
        endcase
    endfunction

    // empty IV, body and tag regions are stepped over
    task automatic open_region(input parse_st_t s);
        parse_st_t r;
        r = s;
        while ((r == ST_IV || r == ST_BODY || r == ST_TAG) && region_span(r) == 64'd0)
            r = next_region(r);
        st         = r;
        region_cnt = '0;
        shift_acc  = '0;
    endtask

    function automatic logic [1:0] take_lengths(input logic [63:0] len, input logic [63:0] ovh);
        body_len = len;
        if (len > LEN_MAX || len > LEN_MAX - ovh)
            return ERR_LIMIT;
        total_len = len + ovh;
        return ERR_NONE;
    endfunction

    task automatic label_byte(input in_word_t w, output out_word_t o);
        parse_st_t   p;
        logic [63:0] v;
        logic [63:0] ovh;
        logic [2:0]  rg;
        logic        last;
        logic [1:0]  err;
        rg   = REGION_TAG;
        last = 1'b0;
        err  = ERR_NONE;
        ovh  = {56'd0, iv_len} + {56'd0, tag_len};
        if (w.restart)
        begin
            st       = ST_START;
            held_err = ERR_NONE;
        end
        if (st == ST_START)
        begin
            seq_no    = '0;
            body_len  = '0;
            total_len = '0;
            if (max_frame == 32'd0)
            begin
                kind   = KIND_SINGLE;
                seq_no = 32'd1;
                open_region(ST_IV);
            end
            else
            begin
                kind = KIND_REG;
                open_region(ST_SEQ);
            end
        end
        if (st != ST_ERR)
        begin
            p = st;
            case (p)
                ST_SEQ:  rg = REGION_SEQ;
                ST_FSEQ: rg = REGION_FSEQ;
                ST_IV:   rg = REGION_IV;
                ST_LEN:  rg = REGION_LEN;
                ST_BODY: rg = REGION_BODY;
                default: rg = REGION_TAG;
            endcase
            shift_acc  = {shift_acc[55:0], w.data_byte};
            region_cnt = region_cnt + 64'd1;
            if (region_cnt >= region_span(p))
            begin
                v = shift_acc;
                case (p)
                    ST_SEQ:
                    begin
                        if (v[31:0] == FINAL_MARK)
                            kind = KIND_FINAL;
                        else
                        begin
                            seq_no = v[31:0];
                            err    = take_lengths({32'd0, max_frame}, ovh + 64'd4);
                        end
                    end
                    ST_FSEQ: seq_no = v[31:0];
                    ST_LEN:
                    begin
                        if (kind == KIND_FINAL)
                        begin
                            if (v[31:0] > max_frame)
                            begin
                                body_len = {32'd0, v[31:0]};
                                err      = ERR_FINAL_LEN;
                            end
                            else
                                err = take_lengths({32'd0, v[31:0]}, ovh + 64'd12);
                        end
                        else
                            err = take_lengths(v, ovh + 64'd8);
                    end
                    default: ;
                endcase
                if (err != ERR_NONE)
                begin
                    held_err = err;
                    st       = ST_ERR;
                end
                else
                begin
                    open_region(next_region(p));
                    if (st == ST_DONE)
                    begin
                        last = 1'b1;
                        st   = ST_START;
                    end
                end
            end
        end
        o.byte_out     = w.data_byte;
        o.region       = rg;
        o.frame_kind   = kind;
        o.frame_seq    = seq_no;
        o.body_length  = body_len[35:0];
        o.frame_length = total_len[35:0];
        o.frame_done   = last;
        o.error_code   = held_err;
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (errs < 100)
            $display("%0t ns word %0d %s: got 0x%0h, expected 0x%0h",
                     $time, word_no, what, got, want);
        errs++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report(name, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t lbl;
        if (!rst_n)
        begin
            max_frame  = MAX_FRAME_RESET;
            iv_len     = IV_RESET;
            tag_len    = TAG_RESET;
            st         = ST_START;
            region_cnt = '0;
            shift_acc  = '0;
            seq_no     = '0;
            body_len   = '0;
            total_len  = '0;
            kind       = KIND_REG;
            held_err   = ERR_NONE;
            awaited_labels.delete();
            queued <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MAX_FRAME: max_frame = cfg_data;
                    CFG_IV:        iv_len    = cfg_data[7:0];
                    CFG_TAG:       tag_len   = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                label_byte(in_word, lbl);
                awaited_labels.push_back(lbl);
            end
            if (out_valid && out_ready)
            begin
                if (awaited_labels.size() == 0)
                    report("unexpected word", 64'(out_word.byte_out), 64'd0);
                else
                begin
                    lbl = awaited_labels.pop_front();
                    check_field("byte_out", 64'(out_word.byte_out), 64'(lbl.byte_out));
                    check_field("region", 64'(out_word.region), 64'(lbl.region));
                    check_field("frame_kind", 64'(out_word.frame_kind),
                                64'(lbl.frame_kind));
                    check_field("frame_seq", 64'(out_word.frame_seq), 64'(lbl.frame_seq));
                    check_field("body_length", 64'(out_word.body_length),
                                64'(lbl.body_length));
                    check_field("frame_length", 64'(out_word.frame_length),
                                64'(lbl.frame_length));
                    check_field("frame_done", 64'(out_word.frame_done),
                                64'(lbl.frame_done));
                    check_field("error_code", 64'(out_word.error_code),
                                64'(lbl.error_code));
                end
                word_no++;
            end
            queued <= awaited_labels.size();
        end
    end

endmodule

@@ bench/encrypted_body_frame_deframer_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for encrypted_body_frame_deframer: clock, reset, framed byte stimulus
// with burst/gap idling, receiver stalls, config phases and the verdict.
// Depends on ebfd_pkg, the deframer RTL and ebfd_frame_checker.

module encrypted_body_frame_deframer_tb;
    import ebfd_pkg::*;

    typedef enum int { PLAN_GOOD, PLAN_OVERSIZE, PLAN_CUT, PLAN_NOISE } frame_plan_t;
    typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD } stall_t;

    localparam int          ITEM_TARGET = 1600;
    localparam int          PHASE_ITEMS = 120;
    localparam int          CYCLE_LIMIT = 800000;
    localparam int          N_FIXED     = 8;
    localparam int          N_DIRECTED  = 23;
    localparam logic [63:0] LEN_MAX     = 64'h0000_000F_FFFF_FFFF;

    localparam logic [31:0] FIXED_MAX [N_FIXED] = '{32'd4096, 32'd3, 32'd0, 32'd1,
                                                    32'd0, 32'hFFFF_FFFF, 32'd16, 32'd0};
    localparam logic [7:0]  FIXED_IV  [N_FIXED] = '{8'd12, 8'd1, 8'd4, 8'd0,
                                                    8'd0, 8'd255, 8'd3, 8'd2};
    localparam logic [7:0]  FIXED_TAG [N_FIXED] = '{8'd16, 8'd2, 8'd4, 8'd0,
                                                    8'd0, 8'd255, 8'd0, 8'd255};

    // {restart, byte}: regular frame, then a final frame whose length is over the max
    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        9'h1FF, 9'h0FF, 9'h0FF, 9'h0FE, 9'h000, 9'h0FF, 9'h000, 9'h080,
        9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h000, 9'h000, 9'h000, 9'h007,
        9'h05A, 9'h000, 9'h000, 9'h000, 9'h003, 9'h0FF, 9'h100
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_word_t   out_word;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_MAX_FRAME;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;

    int          cycles = 0;
    int          sent = 0;
    int          burst_left = 0;
    bit          need_restart = 1'b0;
    logic [31:0] cur_max = MAX_FRAME_RESET;
    logic [7:0]  cur_iv = IV_RESET;
    logic [7:0]  cur_tag = TAG_RESET;
    logic [7:0]  frame_q [$];
    stall_t      rx_mode = RX_OPEN;
    int          rx_left = 0;

    encrypted_body_frame_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ebfd_frame_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= stall_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(4, 40);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= 1'b0;
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic r);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 48);
        end
        in_word  <= '{data_byte: b, restart: r};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] m, input logic [7:0] iv, input logic [7:0] tag);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MAX_FRAME;
        cfg_data  <= m;
        @(posedge clk);
        cfg_index <= CFG_IV;
        cfg_data  <= {24'd0, iv};
        @(posedge clk);
        cfg_index <= CFG_TAG;
        cfg_data  <= {24'd0, tag};
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_max = m;
        cur_iv  = iv;
        cur_tag = tag;
    endtask

    task automatic push_be(input logic [63:0] value, input int n);
        for (int i = n - 1; i >= 0; i--)
            frame_q.push_back(value[8*i +: 8]);
    endtask

    task automatic push_rand(input int n);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic run_frame(input frame_plan_t plan);
        logic [63:0] len;
        logic [63:0] ovh;
        logic [31:0] seqn;
        int          keep;
        frame_plan_t how;
        bit          fin;
        logic        rs;
        how = plan;
        frame_q.delete();
        if (how == PLAN_NOISE)
            push_rand($urandom_range(1, 10));
        else if (cur_max != 32'd0)
        begin
            fin = (how == PLAN_OVERSIZE) || ($urandom_range(0, 2) == 0);
            if (!fin)
            begin
                seqn = ($urandom_range(0, 7) == 0) ? FINAL_MARK - 32'd1 : $urandom;
                if (seqn == FINAL_MARK)
                    seqn = 32'd0;
                push_be({32'd0, seqn}, 4);
                push_rand(int'(cur_iv));
                // long regular bodies are only ever started, then cut
                if (cur_max > 32'd64)
                begin
                    how = PLAN_CUT;
                    push_rand(64);
                end
                else
                    push_rand(int'(cur_max));
                push_rand(int'(cur_tag));
            end
            else
            begin
                push_be({32'd0, FINAL_MARK}, 4);
                push_be({32'd0, $urandom}, 4);
                push_rand(int'(cur_iv));
                if (how == PLAN_OVERSIZE && cur_max != 32'hFFFF_FFFF)
                begin
                    len = {32'd0, cur_max} + 64'd1 + 64'($urandom_range(0, 3));
                    if (len > 64'hFFFF_FFFF || $urandom_range(0, 3) == 0)
                        len = 64'hFFFF_FFFF;
                    push_be(len, 4);
                    push_rand($urandom_range(0, 3));
                end
                else
                begin
                    if (how == PLAN_OVERSIZE)
                        how = PLAN_GOOD;
                    case ($urandom_range(0, 3))
                        0:       len = 64'd0;
                        1:       len = (cur_max > 32'd64) ? 64'd64 : {32'd0, cur_max};
                        default: len = 64'($urandom_range(0, (cur_max > 32'd20) ? 20 : cur_max));
                    endcase
                    push_be(len, 4);
                    push_rand(int'(len));
                    push_rand(int'(cur_tag));
                end
            end
        end
        else
        begin
            ovh = 64'd8 + 64'(cur_iv) + 64'(cur_tag);
            push_rand(int'(cur_iv));
            if (how == PLAN_OVERSIZE)
            begin
                case ($urandom_range(0, 3))
                    0:       len = LEN_MAX - ovh + 64'd1;
                    1:       len = LEN_MAX - ovh;
                    2:       len = {$urandom, $urandom} | 64'h0000_0010_0000_0000;
                    default: len = '1;
                endcase
                push_be(len, 8);
                push_rand($urandom_range(0, 3));
            end
            else
            begin
                len = 64'($urandom_range(0, 20));
                push_be(len, 8);
                push_rand(int'(len));
                push_rand(int'(cur_tag));
            end
        end
        if (how == PLAN_CUT && frame_q.size() > 1)
        begin
            keep = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > keep)
                void'(frame_q.pop_back());
        end
        foreach (frame_q[i])
        begin
            rs = (i == 0 && (need_restart || $urandom_range(0, 3) == 0))
                 || (how == PLAN_NOISE && $urandom_range(0, 3) == 0);
            send_byte(frame_q[i], rs);
        end
        need_restart = (how != PLAN_GOOD);
    endtask

    initial
    begin : stimulus
        int          roll;
        int          phase_no;
        int          phase_start;
        frame_plan_t plan;
        logic [31:0] m;
        logic [7:0]  iv;
        logic [7:0]  tag;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(32'd2, 8'd1, 8'd1);
        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        need_restart = 1'b1;
        phase_no = 0;
        while (sent < ITEM_TARGET)
        begin
            drain();
            if (phase_no < N_FIXED)
                set_config(FIXED_MAX[phase_no], FIXED_IV[phase_no], FIXED_TAG[phase_no]);
            else
            begin
                case ($urandom_range(0, 5))
                    0:       m = 32'd0;
                    1:       m = $urandom;
                    2:       m = $urandom_range(1, 4);
                    default: m = $urandom_range(1, 24);
                endcase
                iv  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
                tag = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
                set_config(m, iv, tag);
            end
            run_frame(PLAN_OVERSIZE);
            phase_start = sent;
            while (sent - phase_start < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    plan = PLAN_GOOD;
                else if (roll < 80)
                    plan = PLAN_OVERSIZE;
                else if (roll < 92)
                    plan = PLAN_CUT;
                else
                    plan = PLAN_NOISE;
                run_frame(plan);
            end
            phase_no++;
        end
        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ebfd_pkg.sv
hw/rtl/ebfd_cfg.sv
hw/rtl/encrypted_body_frame_deframer.sv
bench/ebfd_frame_checker.sv
bench/encrypted_body_frame_deframer_tb.sv
